// ----- rtl/rate_limited_poll_scheduler_top_assert.svh -----
// Assertion macros for the poll scheduler RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef RATE_LIMITED_POLL_SCHEDULER_TOP_ASSERT_SVH
`define RATE_LIMITED_POLL_SCHEDULER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define RLPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define RLPS_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RLPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define RLPS_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/rlps_pkg.sv -----
// Shared types, codes and helper functions of the poll scheduler.
// No dependencies.
package rlps_pkg;

    localparam int NUM_SLOTS = 13;
    localparam int MASK_W    = 13;
    localparam int SLOT_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [SLOT_W-1:0] LOCATION_SLOT = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] CELL_SLOT     = SLOT_W'(11);
    localparam logic [SLOT_W-1:0] MODE_SLOT     = SLOT_W'(12);

    localparam logic [31:0] MODE_INTERVAL_RST     = 32'(5000 * 1000);
    localparam logic [31:0] LOCATION_INTERVAL_RST = 32'(1500 * 1000);
    localparam logic [7:0]  INDEX_BASE            = 8'h40;
    localparam logic [7:0]  MODE_STBY             = 8'h00;

    localparam logic [2:0] REQ_POLL      = 3'd0;
    localparam logic [2:0] REQ_RESP      = 3'd1;
    localparam logic [2:0] REQ_MODE_RESP = 3'd2;
    localparam logic [2:0] REQ_TMO       = 3'd3;
    localparam logic [2:0] REQ_FAIL      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MASK      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_CNT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_INTV = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LOC_INTV  = CFG_IDX_W'(3);

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] time_us;
        logic [7:0]  mode_byte;
    } t_in;

    typedef struct packed {
        logic              issued;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        index_byte;
        logic              polling_on;
        logic              busy_res;
        logic [7:0]        current_mode;
    } t_out;

    typedef struct packed {
        logic [MASK_W-1:0] slot_enable_mask;
        logic [7:0]        cell_count;
        logic [31:0]       mode_interval;
        logic [31:0]       location_interval;
        logic              mask_wr;
        logic [MASK_W-1:0] mask_new;
    } t_cfg;

    // lowest enabled slot, 0 when none
    function automatic logic [SLOT_W-1:0] first_slot(input logic [MASK_W-1:0] mask);
        logic [SLOT_W-1:0] res;
        res = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (i < MASK_W && mask[i]) res = SLOT_W'(i);
        end
        return res;
    endfunction

    // next enabled slot after s around the ring, 0 when none
    function automatic logic [SLOT_W-1:0] next_slot(input logic [MASK_W-1:0] mask,
                                                  input logic [SLOT_W-1:0] s);
        logic [SLOT_W:0]   sum;
        logic [SLOT_W-1:0] c;
        logic [SLOT_W-1:0] res;
        res = '0;
        for (int k = NUM_SLOTS; k >= 1; k--) begin
            sum = {1'b0, s} + (SLOT_W + 1)'(k);
            if (sum >= (SLOT_W + 1)'(NUM_SLOTS)) sum = sum - (SLOT_W + 1)'(NUM_SLOTS);
            c = sum[SLOT_W-1:0];
            if (mask[c]) res = c;
        end
        return res;
    endfunction

endpackage

// ----- rtl/rate_limited_poll_scheduler_top.sv -----
// Path: an accepted item waits in the input register, and its result in the result register.
// Throughput: one item per cycle unless the output stalls; the step is one combinational pass.
// Result register holds a waiting result; while it waits, an empty input register still takes a new item.
// Reset: synchronous, active low; all scheduler state and config return to defaults at once.
// Top level of the poll scheduler; depends on rlps_pkg, rlps_cfg and rlps_sched.
module rate_limited_poll_scheduler_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  rlps_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output rlps_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_we,
    input  logic [rlps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rlps_pkg::CFG_W-1:0]     i_cfg_data
);

    logic           r_in_vld;
    rlps_pkg::t_in  r_in;
    logic           r_out_vld;
    rlps_pkg::t_out r_out;
    logic           go;
    rlps_pkg::t_cfg cfg;
    rlps_pkg::t_out res;

    assign go         = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !go;

    rlps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rlps_sched u_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_in_stall) r_in_vld <= i_in_valid;
            if (go) r_out_vld <= 1'b1;
            else if (!i_out_stall) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) r_in <= i_in_data;
        if (go) r_out <= res;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/rlps_cfg.sv -----
// Configuration register file of the poll scheduler.
// Depends on rlps_pkg.
module rlps_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rlps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rlps_pkg::CFG_W-1:0]    i_cfg_data,
    output rlps_pkg::t_cfg                o_cfg
);

    logic [rlps_pkg::MASK_W-1:0] r_mask;
    logic [7:0]                  r_cell_cnt;
    logic [31:0]                 r_mode_intv;
    logic [31:0]                 r_loc_intv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_cell_cnt  <= '0;
            r_mode_intv <= rlps_pkg::MODE_INTERVAL_RST;
            r_loc_intv  <= rlps_pkg::LOCATION_INTERVAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rlps_pkg::CFG_MASK:      r_mask      <= i_cfg_data[rlps_pkg::MASK_W-1:0];
                rlps_pkg::CFG_CELL_CNT:  r_cell_cnt  <= i_cfg_data[7:0];
                rlps_pkg::CFG_MODE_INTV: r_mode_intv <= i_cfg_data[31:0];
                rlps_pkg::CFG_LOC_INTV:  r_loc_intv  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.slot_enable_mask  = r_mask;
    assign o_cfg.cell_count        = r_cell_cnt;
    assign o_cfg.mode_interval     = r_mode_intv;
    assign o_cfg.location_interval = r_loc_intv;
    assign o_cfg.mask_wr           = i_cfg_we && (i_cfg_idx == rlps_pkg::CFG_MASK);
    assign o_cfg.mask_new          = i_cfg_data[rlps_pkg::MASK_W-1:0];

endmodule

// ----- rtl/rlps_sched.sv -----
// Scheduler state and combinational event step.
// Depends on rlps_pkg and the assertion macro header.
`include "rate_limited_poll_scheduler_top_assert.svh"

module rlps_sched (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  rlps_pkg::t_in  i_item,
    input  rlps_pkg::t_cfg i_cfg,
    output rlps_pkg::t_out o_res
);

    logic                        r_outst, n_outst;
    logic                        r_resp, n_resp;
    logic                        r_tmo, n_tmo;
    logic                        r_fail, n_fail;
    logic [rlps_pkg::SLOT_W-1:0] r_pos, n_pos;
    logic [7:0]                  r_cnt, n_cnt;
    logic [7:0]                  r_limit, n_limit;
    logic [31:0]                 r_mode_stamp, n_mode_stamp;
    logic [31:0]                 r_loc_stamp, n_loc_stamp;
    logic                        r_enable, n_enable;
    logic [7:0]                  r_mode, n_mode;

    logic                        retire;
    logic                        outst_mid;
    logic                        send;
    logic                        adv;
    logic [7:0]                  cnt_mid;
    logic [31:0]                 mode_age;
    logic [31:0]                 loc_age;
    logic [rlps_pkg::SLOT_W-1:0] npos;
    logic [rlps_pkg::SLOT_W-1:0] fpos;
    logic                        issued;
    logic [rlps_pkg::SLOT_W-1:0] sent_slot;
    logic [7:0]                  idx;

    assign mode_age = i_item.time_us - r_mode_stamp;
    assign loc_age  = i_item.time_us - r_loc_stamp;
    assign npos     = rlps_pkg::next_slot(i_cfg.slot_enable_mask, r_pos);
    assign fpos     = rlps_pkg::first_slot(i_cfg.mask_new);

    always_comb begin
        n_outst      = r_outst;
        n_resp       = r_resp;
        n_tmo        = r_tmo;
        n_fail       = r_fail;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_limit      = r_limit;
        n_mode_stamp = r_mode_stamp;
        n_loc_stamp  = r_loc_stamp;
        n_enable     = r_enable;
        n_mode       = r_mode;
        retire       = 1'b0;
        outst_mid    = r_outst;
        send         = 1'b0;
        adv          = 1'b0;
        cnt_mid      = r_cnt;
        issued       = 1'b0;
        sent_slot    = '0;
        idx          = '0;
        if (i_go) begin
            case (i_item.req_type)
                rlps_pkg::REQ_POLL: begin
                    retire = r_outst && (r_fail || r_resp || r_tmo);
                    if (retire) begin
                        outst_mid = 1'b0;
                        n_outst   = 1'b0;
                        n_tmo     = 1'b0;
                    end
                    if (r_enable && !outst_mid && (i_cfg.slot_enable_mask != '0)) begin
                        send = 1'b1;
                        if (r_pos == rlps_pkg::MODE_SLOT) begin
                            if (mode_age < i_cfg.mode_interval) send = 1'b0;
                            else n_mode_stamp = i_item.time_us;
                        end else if (r_pos == rlps_pkg::LOCATION_SLOT) begin
                            if (loc_age < i_cfg.location_interval) send = 1'b0;
                            else n_loc_stamp = i_item.time_us;
                        end
                        if (send) begin
                            n_outst   = 1'b1;
                            n_resp    = 1'b0;
                            n_tmo     = 1'b0;
                            n_fail    = 1'b0;
                            issued    = 1'b1;
                            sent_slot = r_pos;
                            if (r_pos == rlps_pkg::CELL_SLOT) begin
                                idx     = rlps_pkg::INDEX_BASE + r_cnt;
                                cnt_mid = r_cnt + 8'd1;
                            end
                        end
                        n_cnt = cnt_mid;
                        adv   = (r_pos == rlps_pkg::CELL_SLOT) ? (cnt_mid >= r_limit) : 1'b1;
                        if (adv) begin
                            n_pos = npos;
                            if (npos == rlps_pkg::CELL_SLOT) begin
                                n_cnt   = '0;
                                n_limit = i_cfg.cell_count;
                            end
                        end
                    end
                end
                rlps_pkg::REQ_RESP: begin
                    n_resp = 1'b1;
                end
                rlps_pkg::REQ_MODE_RESP: begin
                    n_resp = 1'b1;
                    if (i_item.mode_byte != r_mode) begin
                        if (r_enable && r_mode != rlps_pkg::MODE_STBY &&
                            i_item.mode_byte == rlps_pkg::MODE_STBY) begin
                            n_enable = 1'b0;
                        end else if (!r_enable && r_mode == rlps_pkg::MODE_STBY &&
                                     i_item.mode_byte != rlps_pkg::MODE_STBY) begin
                            n_enable = 1'b1;
                        end
                        n_mode = i_item.mode_byte;
                    end
                end
                rlps_pkg::REQ_TMO: begin
                    n_tmo = 1'b1;
                end
                rlps_pkg::REQ_FAIL: begin
                    n_fail = 1'b1;
                end
                default: ;
            endcase
        end else if (i_cfg.mask_wr) begin
            n_pos   = fpos;
            n_cnt   = '0;
            n_limit = (fpos == rlps_pkg::CELL_SLOT) ? i_cfg.cell_count : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst      <= 1'b0;
            r_resp       <= 1'b0;
            r_tmo        <= 1'b0;
            r_fail       <= 1'b0;
            r_pos        <= '0;
            r_cnt        <= '0;
            r_limit      <= '0;
            r_mode_stamp <= '0;
            r_loc_stamp  <= '0;
            r_enable     <= 1'b1;
            r_mode       <= '0;
        end else begin
            r_outst      <= n_outst;
            r_resp       <= n_resp;
            r_tmo        <= n_tmo;
            r_fail       <= n_fail;
            r_pos        <= n_pos;
            r_cnt        <= n_cnt;
            r_limit      <= n_limit;
            r_mode_stamp <= n_mode_stamp;
            r_loc_stamp  <= n_loc_stamp;
            r_enable     <= n_enable;
            r_mode       <= n_mode;
        end
    end

    assign o_res.issued       = issued;
    assign o_res.slot         = sent_slot;
    assign o_res.index_byte   = idx;
    assign o_res.polling_on   = n_enable;
    assign o_res.busy_res     = n_outst;
    assign o_res.current_mode = n_mode;

    `RLPS_ASSERT(a_issue_sets_busy, i_clk, i_rst_n, (i_go && issued) |=> r_outst, "issue without outstanding")
    `RLPS_ASSERT(a_issue_enabled_slot, i_clk, i_rst_n, (i_go && issued) |-> i_cfg.slot_enable_mask[sent_slot], "issued slot not enabled")
    `RLPS_ASSERT(a_pos_enabled, i_clk, i_rst_n, (i_cfg.slot_enable_mask != '0) |-> i_cfg.slot_enable_mask[r_pos], "position on disabled slot")
    `RLPS_ASSERT(a_cell_bound, i_clk, i_rst_n, (r_pos == rlps_pkg::CELL_SLOT) |-> (r_cnt < r_limit || r_cnt == 8'd0), "cell counter past limit")
    `RLPS_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> (!r_outst && r_enable), "reset state wrong")

endmodule

// ----- bench/rate_limited_poll_scheduler_top_test.sv -----
// Self-checking bench for rate_limited_poll_scheduler_top: a directed table, then random phases,
// results checked against table values or an in-bench scheduler model, with random idling and stalls in some phases.
// Depends on rlps_pkg and the RTL of the scheduler.
module rate_limited_poll_scheduler_top_test;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          NUM_PHASES  = 10;
    localparam int          PHASE_ITEMS = 95;
    localparam int          HOLD_CYCLES = 60;
    localparam logic [2:0]  REQ_BAD_LO  = 3'd5;
    localparam logic [2:0]  REQ_BAD_HI  = 3'd7;
    localparam logic [31:0] RATED_SLOTS = (32'd1 << rlps_pkg::LOCATION_SLOT)
                                        | (32'd1 << rlps_pkg::CELL_SLOT)
                                        | (32'd1 << rlps_pkg::MODE_SLOT);

    typedef enum logic [1:0] {ROW_TYPED, ROW_ITEM, ROW_CFG} t_row_kind;

    // config rows carry the register value in item.time_us
    typedef struct {
        t_row_kind                            kind;
        logic [rlps_pkg::CFG_IDX_W-1:0]       reg_idx;
        rlps_pkg::t_in                        item;
        rlps_pkg::t_out                       want;
    } t_stim_row;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    rlps_pkg::t_in                  in_data   = '0;
    logic                           out_stall = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [rlps_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [rlps_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                           in_stall;
    logic                           out_valid;
    rlps_pkg::t_out                 out_data;

    // scheduler model state
    logic [rlps_pkg::MASK_W-1:0] en_mask         = '0;
    logic [7:0]                  cells_per_round = '0;
    logic [31:0]                 mode_gap        = rlps_pkg::MODE_INTERVAL_RST;
    logic [31:0]                 loc_gap         = rlps_pkg::LOCATION_INTERVAL_RST;
    logic                        pend            = 1'b0;
    logic                        seen_resp       = 1'b0;
    logic                        seen_tmo        = 1'b0;
    logic                        seen_fail       = 1'b0;
    logic [rlps_pkg::SLOT_W-1:0] ring_pos        = '0;
    logic [7:0]                  cell_n          = '0;
    logic [7:0]                  cell_max        = '0;
    logic [31:0]                 mode_last       = '0;
    logic [31:0]                 loc_last        = '0;
    logic                        polls_on        = 1'b1;
    logic [7:0]                  veh_mode        = '0;

    rlps_pkg::t_out pending_results[$];
    t_stim_row      dir_tab[29];
    int             idle_pct    = 30;
    bit             hold_req    = 1'b0;
    int unsigned    cycles      = 0;
    int             mismatches  = 0;
    int             n_items     = 0;
    int             n_directed  = 0;
    int             n_results   = 0;
    int             n_issued    = 0;
    int             rate_skips  = 0;
    int             n_writes    = 0;

    rate_limited_poll_scheduler_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic rlps_pkg::t_out schedule_event(input rlps_pkg::t_in it);
        rlps_pkg::t_out              res;
        logic [rlps_pkg::SLOT_W-1:0] s;
        logic                        fire;
        int                          c;
        bit                          found;
        res = '0;
        case (it.req_type)
            rlps_pkg::REQ_POLL: begin
                if (pend && (seen_fail || seen_resp || seen_tmo)) begin
                    pend     = 1'b0;
                    seen_tmo = 1'b0;
                end
                if (polls_on && !pend && en_mask != '0) begin
                    s    = ring_pos;
                    fire = 1'b1;
                    if (s == rlps_pkg::MODE_SLOT) begin
                        if ((it.time_us - mode_last) < mode_gap) fire = 1'b0;
                        else mode_last = it.time_us;
                    end else if (s == rlps_pkg::LOCATION_SLOT) begin
                        if ((it.time_us - loc_last) < loc_gap) fire = 1'b0;
                        else loc_last = it.time_us;
                    end
                    if (fire) begin
                        pend          = 1'b1;
                        seen_resp     = 1'b0;
                        seen_tmo      = 1'b0;
                        seen_fail     = 1'b0;
                        res.issued    = 1'b1;
                        res.slot      = s;
                        if (s == rlps_pkg::CELL_SLOT) begin
                            res.index_byte = rlps_pkg::INDEX_BASE + cell_n;
                            cell_n         = cell_n + 8'd1;
                        end
                    end else begin
                        rate_skips++;
                    end
                    if (s != rlps_pkg::CELL_SLOT || cell_n >= cell_max) begin
                        found    = 1'b0;
                        ring_pos = '0;
                        for (int k = 1; k <= rlps_pkg::NUM_SLOTS; k++) begin
                            c = (int'(s) + k) % rlps_pkg::NUM_SLOTS;
                            if (!found && en_mask[c]) begin
                                ring_pos = rlps_pkg::SLOT_W'(c);
                                found    = 1'b1;
                            end
                        end
                        if (ring_pos == rlps_pkg::CELL_SLOT) begin
                            cell_n   = '0;
                            cell_max = cells_per_round;
                        end
                    end
                end
            end
            rlps_pkg::REQ_RESP: seen_resp = 1'b1;
            rlps_pkg::REQ_MODE_RESP: begin
                seen_resp = 1'b1;
                if (it.mode_byte != veh_mode) begin
                    if (polls_on && veh_mode != rlps_pkg::MODE_STBY
                        && it.mode_byte == rlps_pkg::MODE_STBY)
                        polls_on = 1'b0;
                    else if (!polls_on && veh_mode == rlps_pkg::MODE_STBY
                             && it.mode_byte != rlps_pkg::MODE_STBY)
                        polls_on = 1'b1;
                    veh_mode = it.mode_byte;
                end
            end
            rlps_pkg::REQ_TMO: seen_tmo = 1'b1;
            rlps_pkg::REQ_FAIL: seen_fail = 1'b1;
            default: ;
        endcase
        res.polling_on   = polls_on;
        res.busy_res     = pend;
        res.current_mode = veh_mode;
        return res;
    endfunction

    function automatic logic [31:0] pick_interval();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return '1;
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    task automatic push_item(input rlps_pkg::t_in it, input bit typed,
                             input rlps_pkg::t_out want);
        rlps_pkg::t_out guess;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        guess = schedule_event(it);
        pending_results.push_back(typed ? want : guess);
        n_items++;
        if (guess.issued) n_issued++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rlps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        n_writes++;
        case (idx)
            rlps_pkg::CFG_MASK: begin
                en_mask  = val[rlps_pkg::MASK_W-1:0];
                ring_pos = '0;
                for (int i = rlps_pkg::NUM_SLOTS - 1; i >= 0; i--)
                    if (en_mask[i]) ring_pos = rlps_pkg::SLOT_W'(i);
                cell_n   = '0;
                cell_max = (ring_pos == rlps_pkg::CELL_SLOT) ? cells_per_round : 8'd0;
            end
            rlps_pkg::CFG_CELL_CNT: cells_per_round = val[7:0];
            rlps_pkg::CFG_MODE_INTV: mode_gap = val;
            rlps_pkg::CFG_LOC_INTV: loc_gap = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // out side: random stall bursts, plus one long hold on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        rlps_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", out_data);
            end else begin
                want = pending_results.pop_front();
                n_results++;
                if (out_data.issued !== want.issued || out_data.slot !== want.slot
                    || out_data.index_byte !== want.index_byte
                    || out_data.polling_on !== want.polling_on
                    || out_data.busy_res !== want.busy_res
                    || out_data.current_mode !== want.current_mode) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: exp issued=%0d slot=%0d index=%h on=%0d",
                                  " busy=%0d mode=%h / got issued=%0d slot=%0d index=%h",
                                  " on=%0d busy=%0d mode=%h"}, n_results,
                                 want.issued, want.slot, want.index_byte, want.polling_on,
                                 want.busy_res, want.current_mode, out_data.issued,
                                 out_data.slot, out_data.index_byte, out_data.polling_on,
                                 out_data.busy_res, out_data.current_mode);
                end
            end
        end
    end

    initial begin
        rlps_pkg::t_in it;
        int            counted;
        bit            go_poll;
        int            pick;
        logic [31:0]   now_us;
        int unsigned   tick_max;
        logic [31:0]   mask_w;
        logic [31:0]   cell_w;
        dir_tab = '{
            // no slot enabled, unknown code, response with nothing outstanding
            '{ROW_TYPED, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_POLL, 32'd0, 8'h00},
              '{1'b0, 4'd0, 8'h00, 1'b1, 1'b0, 8'h00}},
            '{ROW_TYPED, rlps_pkg::CFG_MASK, '{REQ_BAD_HI, 32'hffff_ffff, 8'hff},
              '{1'b0, 4'd0, 8'h00, 1'b1, 1'b0, 8'h00}},
            '{ROW_TYPED, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_RESP, 32'd0, 8'h00},
              '{1'b0, 4'd0, 8'h00, 1'b1, 1'b0, 8'h00}},
            '{ROW_CFG, rlps_pkg::CFG_CELL_CNT, '{rlps_pkg::REQ_POLL, 32'd0, 8'h00}, '0},
            '{ROW_CFG, rlps_pkg::CFG_MASK,
              '{rlps_pkg::REQ_POLL, 32'h0000_1fff, 8'h00}, '0},
            '{ROW_TYPED, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_POLL, 32'd0, 8'h00},
              '{1'b1, 4'd0, 8'h00, 1'b1, 1'b1, 8'h00}},
            '{ROW_TYPED, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_POLL, 32'd0, 8'h00},
              '{1'b0, 4'd0, 8'h00, 1'b1, 1'b1, 8'h00}},
            '{ROW_TYPED, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_TMO, 32'd0, 8'h00},
              '{1'b0, 4'd0, 8'h00, 1'b1, 1'b1, 8'h00}},
            // location slot too early: skipped
            '{ROW_TYPED, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_POLL, 32'd0, 8'h00},
              '{1'b0, 4'd0, 8'h00, 1'b1, 1'b0, 8'h00}},
            '{ROW_TYPED, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_POLL, 32'd0, 8'h00},
              '{1'b1, 4'd2, 8'h00, 1'b1, 1'b1, 8'h00}},
            '{ROW_TYPED, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_FAIL, 32'd0, 8'h00},
              '{1'b0, 4'd0, 8'h00, 1'b1, 1'b1, 8'h00}},
            '{ROW_TYPED, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_POLL, 32'd0, 8'h00},
              '{1'b1, 4'd3, 8'h00, 1'b1, 1'b1, 8'h00}},
            // standby entry and exit
            '{ROW_TYPED, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_MODE_RESP, 32'd0, 8'h05},
              '{1'b0, 4'd0, 8'h00, 1'b1, 1'b1, 8'h05}},
            '{ROW_TYPED, rlps_pkg::CFG_MASK,
              '{rlps_pkg::REQ_MODE_RESP, 32'd0, rlps_pkg::MODE_STBY},
              '{1'b0, 4'd0, 8'h00, 1'b0, 1'b1, 8'h00}},
            '{ROW_TYPED, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_POLL, 32'd0, 8'h00},
              '{1'b0, 4'd0, 8'h00, 1'b0, 1'b0, 8'h00}},
            '{ROW_TYPED, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_MODE_RESP, 32'd0, 8'hff},
              '{1'b0, 4'd0, 8'h00, 1'b1, 1'b0, 8'hff}},
            '{ROW_CFG, rlps_pkg::CFG_CELL_CNT, '{rlps_pkg::REQ_POLL, 32'd2, 8'h00}, '0},
            '{ROW_CFG, rlps_pkg::CFG_LOC_INTV, '{rlps_pkg::REQ_POLL, 32'd0, 8'h00}, '0},
            '{ROW_CFG, rlps_pkg::CFG_MODE_INTV,
              '{rlps_pkg::REQ_POLL, 32'hffff_ffff, 8'h00}, '0},
            '{ROW_CFG, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_POLL, RATED_SLOTS, 8'h00}, '0},
            '{ROW_ITEM, rlps_pkg::CFG_MASK,
              '{rlps_pkg::REQ_POLL, 32'hffff_ffff, 8'h00}, '0},
            '{ROW_ITEM, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_RESP, 32'd0, 8'h00}, '0},
            '{ROW_ITEM, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_POLL, 32'd0, 8'h00}, '0},
            '{ROW_ITEM, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_RESP, 32'd0, 8'h00}, '0},
            '{ROW_ITEM, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_POLL, 32'd0, 8'h00}, '0},
            '{ROW_ITEM, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_TMO, 32'd0, 8'h00}, '0},
            // mode slot exactly at the largest interval, then location across the wrap
            '{ROW_ITEM, rlps_pkg::CFG_MASK,
              '{rlps_pkg::REQ_POLL, 32'hffff_ffff, 8'h00}, '0},
            '{ROW_ITEM, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_RESP, 32'd0, 8'h00}, '0},
            '{ROW_ITEM, rlps_pkg::CFG_MASK, '{rlps_pkg::REQ_POLL, 32'd0, 8'h00}, '0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                settle();
                write_reg(dir_tab[r].reg_idx, dir_tab[r].item.time_us);
            end else begin
                push_item(dir_tab[r].item, dir_tab[r].kind == ROW_TYPED, dir_tab[r].want);
                n_directed++;
            end
        end

        now_us = $urandom;
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            idle_pct = (p >= NUM_PHASES - 2 || p % 3 == 2) ? 0 : 35;
            tick_max = $urandom_range(1, 1200);
            if (p == 0) begin
                mask_w = 32'h0000_1fff;
                cell_w = 32'h0000_00ff;
                write_reg(rlps_pkg::CFG_MODE_INTV, 32'd0);
                write_reg(rlps_pkg::CFG_LOC_INTV, 32'd0);
            end else if (p == 1) begin
                mask_w = RATED_SLOTS;
                cell_w = 32'd0;
                write_reg(rlps_pkg::CFG_MODE_INTV, '1);
                write_reg(rlps_pkg::CFG_LOC_INTV, '1);
            end else begin
                case ($urandom_range(0, 3))
                    0: mask_w = 32'h0000_1fff;
                    1: mask_w = 32'd1 << $urandom_range(0, rlps_pkg::NUM_SLOTS - 1);
                    2: mask_w = RATED_SLOTS | ($urandom & 32'h0000_0555);
                    default: mask_w = $urandom;
                endcase
                case ($urandom_range(0, 3))
                    0: cell_w = {24'($urandom), 8'h00};
                    1: cell_w = {24'($urandom), 8'hff};
                    default: cell_w = $urandom_range(1, 5);
                endcase
                write_reg(rlps_pkg::CFG_MODE_INTV, pick_interval());
                write_reg(rlps_pkg::CFG_LOC_INTV, pick_interval());
            end
            write_reg(rlps_pkg::CFG_CELL_CNT, cell_w);
            write_reg(rlps_pkg::CFG_MASK, mask_w);
            if ($urandom_range(0, 2) == 0)
                write_reg(rlps_pkg::CFG_CELL_CNT, $urandom_range(0, 7));

            counted = 0;
            while (counted < PHASE_ITEMS) begin
                it.time_us   = $urandom;
                it.mode_byte = 8'($urandom);
                // mostly poll / completion pairs, with stray events mixed in
                if (pend && !(seen_resp || seen_tmo || seen_fail))
                    go_poll = $urandom_range(0, 99) < 25;
                else
                    go_poll = $urandom_range(0, 99) < 80;
                if (go_poll) begin
                    it.req_type = rlps_pkg::REQ_POLL;
                    if ($urandom_range(0, 49) == 0) now_us = $urandom;
                    else now_us = now_us + $urandom_range(0, tick_max);
                    it.time_us = now_us;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40) begin
                        it.req_type = rlps_pkg::REQ_RESP;
                    end else if (pick < 60) begin
                        it.req_type = rlps_pkg::REQ_TMO;
                    end else if (pick < 75) begin
                        it.req_type = rlps_pkg::REQ_FAIL;
                    end else if (pick < 92) begin
                        it.req_type = rlps_pkg::REQ_MODE_RESP;
                        case ($urandom_range(0, 3))
                            0: it.mode_byte = rlps_pkg::MODE_STBY;
                            1: it.mode_byte = veh_mode;
                            default: ;
                        endcase
                    end else begin
                        it.req_type = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
                    end
                end
                push_item(it, 1'b0, '0);
                if (it.req_type <= rlps_pkg::REQ_FAIL) begin
                    counted++;
                    if (p == 3 && counted == 10) hold_req = 1'b1;
                    if (p == 5 && counted == 30) settle();
                end
            end
        end

        idle_pct = 0;
        settle();
        repeat (8) @(posedge clk);
        $display("%0d items (%0d directed) over %0d register writes, %0d results checked",
                 n_items, n_directed, n_writes, n_results);
        $display("%0d requests issued, %0d rate-limited skips, %0d mismatches",
                 n_issued, rate_skips, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
